### rtl/core/mmcc_pkg.sv
// ----------------------------------------------------------------------------
// mmcc_pkg: shared types and constants of the max colour composite
// Channel setup layout, register indexes and the output clamp.
// ----------------------------------------------------------------------------
`default_nettype none

package mmcc_pkg;

    localparam int NUM_CH    = 4;
    localparam int SETUP_W   = 63;
    localparam int CFG_IDX_W = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN0  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN2  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN3  = 3'd5;

    // per-channel setup word, msb first
    typedef struct packed {
        logic signed [19:0] offset;  // Q12.8
        logic signed [15:0] scale;   // Q8.8
        logic [8:0]         red_w;   // Q1.8
        logic [8:0]         green_w;
        logic [8:0]         blue_w;
    } t_setup;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_rgb;

    // channel zero: unit weights, unit scale, no offset
    localparam logic [SETUP_W-1:0] SETUP0_RST = {20'd0, 16'd256, 9'd256, 9'd256, 9'd256};
    localparam logic [2:0] ACTIVE_RST = 3'd1;
    localparam logic [7:0] ALPHA_RST  = 8'd255;

    // clamp a Q.16 product to an integer byte, truncating
    function automatic logic [7:0] clamp_byte(input logic signed [34:0] p);
        logic [7:0] r;
        if (p <= 35'sd0) begin
            r = 8'd0;
        end else if (|p[33:24]) begin
            r = 8'd255;
        end else begin
            r = p[23:16];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/mmcc_lane.sv
// ----------------------------------------------------------------------------
// mmcc_lane: one channel of the composite
// Maps a sample through scale and offset, then tints and clamps each colour.
// ----------------------------------------------------------------------------
`default_nettype none

module mmcc_lane
    import mmcc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_active,
    input  wire logic [7:0] i_sample,
    input  wire t_setup     i_setup,
    output t_rgb            o_rgb
);

    logic signed [24:0] r_t;
    logic signed [24:0] n_t;
    logic               r_act;
    t_rgb               r_rgb;
    t_rgb               n_rgb;
    logic signed [34:0] prod_b;
    logic signed [34:0] prod_g;
    logic signed [34:0] prod_r;

    // stage one: t = scale * sample + offset in Q.8
    always_comb begin
        n_t = 25'(i_setup.scale * $signed({1'b0, i_sample}))
            + 25'(i_setup.offset);
    end

    always_ff @(posedge i_clk) begin
        r_t   <= n_t;
        r_act <= i_active;
    end

    // stage two: tint products, clamp, drop inactive channels to zero
    always_comb begin
        prod_b = 35'(r_t) * $signed({1'b0, i_setup.blue_w});
        prod_g = 35'(r_t) * $signed({1'b0, i_setup.green_w});
        prod_r = 35'(r_t) * $signed({1'b0, i_setup.red_w});
        if (r_act) begin
            n_rgb.blue  = clamp_byte(prod_b);
            n_rgb.green = clamp_byte(prod_g);
            n_rgb.red   = clamp_byte(prod_r);
        end else begin
            n_rgb = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rgb <= n_rgb;
    end

    assign o_rgb = r_rgb;

endmodule

`default_nettype wire

### rtl/core/mmcc_merge.sv
// ----------------------------------------------------------------------------
// mmcc_merge: combine the lanes
// Takes the per-component maximum over all lanes and registers the pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module mmcc_merge
    import mmcc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire t_rgb       i_lane [NUM_CH],
    input  wire logic [7:0] i_alpha,
    output logic            o_valid,
    output t_rgb            o_rgb,
    output logic [7:0]      o_alpha
);

    logic r_valid;
    t_rgb r_rgb;
    t_rgb n_rgb;
    logic [7:0] r_alpha;

    // running maximum over independent lanes
    always_comb begin
        n_rgb = '0;
        for (int i = 0; i < NUM_CH; i++) begin
            if (i_lane[i].blue  > n_rgb.blue)  n_rgb.blue  = i_lane[i].blue;
            if (i_lane[i].green > n_rgb.green) n_rgb.green = i_lane[i].green;
            if (i_lane[i].red   > n_rgb.red)   n_rgb.red   = i_lane[i].red;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rgb   <= n_rgb;
        r_alpha <= i_alpha;
    end

    assign o_valid = r_valid;
    assign o_rgb   = r_rgb;
    assign o_alpha = r_alpha;

endmodule

`default_nettype wire

### rtl/core/multichannel_max_colour_composite_top.sv
// ----------------------------------------------------------------------------
// multichannel_max_colour_composite_top: pseudocolor max composite
// Up to four tinted channels merged by per-component maximum into BGRA.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_sample0..i_sample3 and raise start for one cycle per pixel. A
//   request is taken at every clock edge with start high and busy low; busy
//   stays low, so one pixel is taken every cycle.
//   Each pixel comes back on o_blue_out, o_green_out, o_red_out and
//   o_alpha_out for exactly one cycle, marked by o_valid. Results leave in
//   request order.
//   Pipeline: a taken request passes three register stages (scale and offset,
//   tint and clamp in each of four lanes, then the max merge and output
//   register) before it is shown.
//   Throughput: one pixel per cycle, set by the fully pipelined lanes.
//   The receiver cannot stall; it must take o_valid pixels as they appear.
//   Configuration: write i_cfg_data to register i_cfg_idx with i_cfg_we;
//   only while no pixel is in flight. Indexes above five are ignored.
//   Reset (i_rst_n low, synchronous) drops all in-flight pixels and restores
//   one active channel, alpha 255 and a unit grey map on channel zero.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_max_colour_composite_top
    import mmcc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [7:0]           i_sample0,
    input  wire logic [7:0]           i_sample1,
    input  wire logic [7:0]           i_sample2,
    input  wire logic [7:0]           i_sample3,
    output logic                      o_valid,
    output logic [7:0]                o_blue_out,
    output logic [7:0]                o_green_out,
    output logic [7:0]                o_red_out,
    output logic [7:0]                o_alpha_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [SETUP_W-1:0]   i_cfg_data
);

    logic [2:0]         r_active;
    logic [7:0]         r_alpha;
    logic [SETUP_W-1:0] r_setup [NUM_CH];
    logic               r_v1;
    logic               r_v2;
    logic [2:0]         n_eff;
    logic [NUM_CH-1:0]  lane_act;
    logic [7:0]         samples [NUM_CH];
    t_rgb               lane_rgb [NUM_CH];
    t_rgb               out_rgb;
    logic               accept;

    // pipelined lanes take a request every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= ACTIVE_RST;
            r_alpha    <= ALPHA_RST;
            r_setup[0] <= SETUP0_RST;
            r_setup[1] <= '0;
            r_setup[2] <= '0;
            r_setup[3] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ACTIVE: r_active   <= i_cfg_data[2:0];
                CFG_ALPHA:  r_alpha    <= i_cfg_data[7:0];
                CFG_CHAN0:  r_setup[0] <= i_cfg_data;
                CFG_CHAN1:  r_setup[1] <= i_cfg_data;
                CFG_CHAN2:  r_setup[2] <= i_cfg_data;
                CFG_CHAN3:  r_setup[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clip the channel count to 1..NUM_CH and enable lanes below it
    always_comb begin
        if (r_active == 3'd0) begin
            n_eff = 3'd1;
        end else if (r_active > 3'(NUM_CH)) begin
            n_eff = 3'(NUM_CH);
        end else begin
            n_eff = r_active;
        end
        for (int i = 0; i < NUM_CH; i++) begin
            lane_act[i] = (3'(i) < n_eff);
        end
    end

    assign samples[0] = i_sample0;
    assign samples[1] = i_sample1;
    assign samples[2] = i_sample2;
    assign samples[3] = i_sample3;

    // advance the request marker alongside the lane stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
        end
    end

    for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
        mmcc_lane u_lane (
            .i_clk    (i_clk),
            .i_active (lane_act[g]),
            .i_sample (samples[g]),
            .i_setup  (t_setup'(r_setup[g])),
            .o_rgb    (lane_rgb[g])
        );
    end

    mmcc_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v2),
        .i_lane  (lane_rgb),
        .i_alpha (r_alpha),
        .o_valid (o_valid),
        .o_rgb   (out_rgb),
        .o_alpha (o_alpha_out)
    );

    assign o_blue_out  = out_rgb.blue;
    assign o_green_out = out_rgb.green;
    assign o_red_out   = out_rgb.red;

`ifndef SYNTH
    // every pixel shown matches an earlier request
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, 3))
        else $error("result without a matching request");

    // every request yields a pixel
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##3 o_valid)
        else $error("request lost in the pipeline");

    // the last lane never contributes a colour while it is inactive
    a_lane_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !$past(lane_act[NUM_CH-1], 2)) |-> (lane_rgb[NUM_CH-1] == '0))
        else $error("inactive lane produced a colour");
`endif

endmodule

`default_nettype wire
